// File: design/rgb_pixel_format_converter_macros.svh
// Assertion macros for the RGB pixel format converter.
// Expects clk and arst_n in the scope of each use.
`ifndef RGB_PIXEL_FORMAT_CONVERTER_MACROS_SVH
`define RGB_PIXEL_FORMAT_CONVERTER_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define RPFC_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define RPFC_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: design/rpfc_pkg.sv
// Shared types and constants of the RGB pixel format converter.
// No dependencies.
package rpfc_pkg;

	localparam int LEVELS     = 256;
	localparam int WORD_W     = 32;
	localparam int COMP_W     = 8;
	localparam int LUMA_W     = 12;
	localparam logic [LUMA_W-1:0] DARK_LIMIT = 12'hc00;

	typedef enum logic [2:0] {
		MODE_BGR24    = 3'd0,
		MODE_RGB24    = 3'd1,
		MODE_MASK16   = 3'd2,
		MODE_MASK32   = 3'd3,
		MODE_GREY8    = 3'd4,
		MODE_PALETTE8 = 3'd5,
		MODE_BITS_MSB = 3'd6,
		MODE_BITS_LSB = 3'd7
	} rpfc_mode_t;

	typedef enum logic [1:0] {
		ACT_PIXEL = 2'd0,
		ACT_COMP  = 2'd1,
		ACT_PAL   = 2'd2
	} rpfc_action_t;

	typedef enum logic [1:0] {
		CH_RED   = 2'd0,
		CH_GREEN = 2'd1,
		CH_BLUE  = 2'd2
	} rpfc_channel_t;

	typedef enum logic {
		REG_FORMAT_MODE = 1'b0,
		REG_XOR_VALUE   = 1'b1
	} rpfc_reg_t;

	typedef struct packed {
		logic step;
		logic dark;
		logic lsb_first;
		logic row_end;
	} rpfc_pack_req_t;

	typedef struct packed {
		logic              emit;
		logic [COMP_W-1:0] bits;
		logic [2:0]        pos;
	} rpfc_pack_t;

endpackage

// File: design/rpfc_if.sv
// Request and result channel interfaces of the RGB pixel format converter.
// No dependencies.
interface rpfc_in_if;
	logic        valid;
	logic        ready;
	logic [1:0]  action;
	logic [7:0]  red;
	logic [7:0]  green;
	logic [7:0]  blue;
	logic        row_end;
	logic [1:0]  table_channel;
	logic [7:0]  table_index;
	logic [31:0] table_word;

	modport source (
		output valid, action, red, green, blue, row_end,
		       table_channel, table_index, table_word,
		input  ready
	);
	modport sink (
		input  valid, action, red, green, blue, row_end,
		       table_channel, table_index, table_word,
		output ready
	);
endinterface

interface rpfc_out_if;
	logic        valid;
	logic        ready;
	logic [31:0] out_value;
	logic [2:0]  out_byte_count;
	logic        row_last;

	modport source (
		output valid, out_value, out_byte_count, row_last,
		input  ready
	);
	modport sink (
		input  valid, out_value, out_byte_count, row_last,
		output ready
	);
endinterface

// File: design/rgb_pixel_format_converter.sv
// Channel    | Dir | Payload
// pixels     | in  | action, red, green, blue, row_end, table_channel, table_index, table_word
// results    | out | out_value, out_byte_count, row_last
// cfg        | in  | cfg_we, cfg_index, cfg_data (write only)
// One request per cycle while pixels.ready is high; each result is registered in s1, s2 and the output register.
// Registers: component table read (s1), converted word with palette read (s2), output.
// One enable moves all stages; pixels.ready drops only while a result waits.
// Tables are undefined after reset; no clearing pass.
// Top level of the RGB pixel format converter.
// Depends on rpfc_pkg, rpfc_if, rpfc_ram, rpfc_bilevel and the macros header.
`include "rgb_pixel_format_converter_macros.svh"

module rgb_pixel_format_converter #(
	parameter int LEVELS = rpfc_pkg::LEVELS
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_we,
	input  logic                        cfg_index,
	input  logic [rpfc_pkg::WORD_W-1:0] cfg_data,
	rpfc_in_if.sink                     pixels,
	rpfc_out_if.source                  results
);

	localparam int AW = $clog2(LEVELS);
	localparam int W  = rpfc_pkg::WORD_W;

	rpfc_pkg::rpfc_mode_t    mode_q;
	logic [W-1:0]            xor_q;

	logic                    adv;
	logic                    accept;
	logic [7:0]              comp_in [3];
	logic [W-1:0]            comp_rd [3];

	logic                    v_s1;
	rpfc_pkg::rpfc_action_t  act_s1;
	logic [7:0]              red_s1;
	logic [7:0]              green_s1;
	logic [7:0]              blue_s1;
	logic                    row_s1;

	logic                    is_pix;
	logic                    bilevel;
	logic [rpfc_pkg::LUMA_W-1:0] luma;
	logic [W-1:0]            mask_w;
	logic [W+1:0]            sum;
	logic [AW-1:0]           pal_addr;
	logic [7:0]              pal_rd;
	rpfc_pkg::rpfc_pack_req_t pack_req;
	rpfc_pkg::rpfc_pack_t    pack_st;
	logic [W-1:0]            value_n;
	logic [2:0]              count_n;

	logic                    v_s2;
	logic [W-1:0]            value_s2;
	logic [2:0]              count_s2;
	logic                    row_s2;
	logic                    pal_s2;

	logic                    out_v_q;
	logic [W-1:0]            out_value_q;
	logic [2:0]              out_count_q;
	logic                    out_row_q;

	// Configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= rpfc_pkg::MODE_GREY8;
			xor_q  <= '0;
		end else if (cfg_we) begin
			unique case (rpfc_pkg::rpfc_reg_t'(cfg_index))
				rpfc_pkg::REG_FORMAT_MODE: mode_q <= rpfc_pkg::rpfc_mode_t'(cfg_data[2:0]);
				rpfc_pkg::REG_XOR_VALUE:   xor_q  <= cfg_data;
			endcase
		end
	end

	assign adv          = !out_v_q || results.ready;
	assign pixels.ready = adv;
	assign accept       = pixels.valid && adv;

	assign comp_in[0] = pixels.red;
	assign comp_in[1] = pixels.green;
	assign comp_in[2] = pixels.blue;

	// Component tables, one per channel
	for (genvar ch = 0; ch < 3; ch++) begin : g_comp
		rpfc_ram #(
			.WIDTH(W),
			.DEPTH(LEVELS)
		) u_comp_ram (
			.clk  (clk),
			.we   (accept && (pixels.action == rpfc_pkg::ACT_COMP)
			       && (pixels.table_channel == 2'(ch))),
			.waddr(pixels.table_index[AW-1:0]),
			.wdata(pixels.table_word),
			.re   (adv),
			.raddr(comp_in[ch][AW-1:0]),
			.rdata(comp_rd[ch])
		);
	end

	// Stage 1: request fields alongside the component reads
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (adv) begin
			v_s1 <= pixels.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			act_s1   <= rpfc_pkg::rpfc_action_t'(pixels.action);
			red_s1   <= pixels.red;
			green_s1 <= pixels.green;
			blue_s1  <= pixels.blue;
			row_s1   <= pixels.row_end;
		end
	end

	always_comb begin
		is_pix   = v_s1 && (act_s1 == rpfc_pkg::ACT_PIXEL);
		bilevel  = (mode_q == rpfc_pkg::MODE_BITS_MSB) || (mode_q == rpfc_pkg::MODE_BITS_LSB);
		luma     = rpfc_pkg::LUMA_W'(red_s1) * 12'd5 + rpfc_pkg::LUMA_W'(green_s1) * 12'd9
		         + rpfc_pkg::LUMA_W'(blue_s1) * 12'd2;
		mask_w   = (comp_rd[0] | comp_rd[1] | comp_rd[2]) ^ xor_q;
		sum      = (W+2)'(comp_rd[0]) + (W+2)'(comp_rd[1]) + (W+2)'(comp_rd[2]);
		pal_addr = (sum > (W+2)'(LEVELS - 1)) ? '1 : sum[AW-1:0];
	end

	assign pack_req.step      = adv && is_pix && bilevel;
	assign pack_req.dark      = luma < rpfc_pkg::DARK_LIMIT;
	assign pack_req.lsb_first = mode_q == rpfc_pkg::MODE_BITS_LSB;
	assign pack_req.row_end   = row_s1;

	rpfc_bilevel u_bilevel (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (pack_req),
		.st    (pack_st)
	);

	always_comb begin
		unique case (mode_q)
			rpfc_pkg::MODE_BGR24: begin
				value_n = {8'h00, red_s1, green_s1, blue_s1};
				count_n = 3'd3;
			end
			rpfc_pkg::MODE_RGB24: begin
				value_n = {8'h00, blue_s1, green_s1, red_s1};
				count_n = 3'd3;
			end
			rpfc_pkg::MODE_MASK16: begin
				value_n = {16'h0000, mask_w[15:0]};
				count_n = 3'd2;
			end
			rpfc_pkg::MODE_MASK32: begin
				value_n = mask_w;
				count_n = 3'd4;
			end
			rpfc_pkg::MODE_GREY8: begin
				value_n = {24'h000000, luma[11:4]};
				count_n = 3'd1;
			end
			rpfc_pkg::MODE_PALETTE8: begin
				value_n = '0;
				count_n = 3'd1;
			end
			rpfc_pkg::MODE_BITS_MSB, rpfc_pkg::MODE_BITS_LSB: begin
				value_n = {24'h000000, pack_st.bits};
				count_n = 3'd1;
			end
		endcase
	end

	// Palette
	rpfc_ram #(
		.WIDTH(8),
		.DEPTH(LEVELS)
	) u_pal_ram (
		.clk  (clk),
		.we   (accept && (pixels.action == rpfc_pkg::ACT_PAL)),
		.waddr(pixels.table_index[AW-1:0]),
		.wdata(pixels.table_word[7:0]),
		.re   (adv),
		.raddr(pal_addr),
		.rdata(pal_rd)
	);

	// Stage 2: converted word alongside the palette read
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (adv) begin
			v_s2 <= is_pix && (!bilevel || pack_st.emit);
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			value_s2 <= value_n;
			count_s2 <= count_n;
			row_s2   <= row_s1;
			pal_s2   <= mode_q == rpfc_pkg::MODE_PALETTE8;
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (adv) begin
			out_v_q <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			out_value_q <= pal_s2 ? {24'h000000, pal_rd} : value_s2;
			out_count_q <= count_s2;
			out_row_q   <= row_s2;
		end
	end

	assign results.valid          = out_v_q;
	assign results.out_value      = out_value_q;
	assign results.out_byte_count = out_count_q;
	assign results.row_last       = out_row_q;

	`RPFC_ASSERT_NEXT(a_pack_clear, pack_req.step && pack_st.emit, pack_st.pos == 3'd0, "pack pos")
	`RPFC_ASSERT_NOW(a_stall_only_full, !pixels.ready, out_v_q, "stall while output empty")
	`RPFC_ASSERT_NOW(a_count_range, out_v_q, (out_count_q != 3'd0) && (out_count_q <= 3'd4), "count")
	`RPFC_ASSERT_NOW(a_high_zero, out_v_q && (out_count_q == 3'd2), out_value_q[31:16] == 16'h0, "high")

endmodule

// File: design/rpfc_ram.sv
// Generic single-write, single-read RAM with registered read data (read-first).
// No dependencies.
module rpfc_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 256,
	parameter int AW    = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// File: design/rpfc_bilevel.sv
// Bilevel packer: collects one bit per pixel into a byte, MSB- or LSB-first.
// Depends on rpfc_pkg.
module rpfc_bilevel (
	input  logic                    clk,
	input  logic                    arst_n,
	input  rpfc_pkg::rpfc_pack_req_t req,
	output rpfc_pkg::rpfc_pack_t     st
);

	logic [rpfc_pkg::COMP_W-1:0] acc_q;
	logic [2:0]                  pos_q;
	logic [2:0]                  shift;
	logic [rpfc_pkg::COMP_W-1:0] bits_n;
	logic                        emit;

	always_comb begin
		shift  = req.lsb_first ? pos_q : ~pos_q;
		bits_n = acc_q | (rpfc_pkg::COMP_W'(req.dark) << shift);
		emit   = (pos_q == 3'd7) || req.row_end;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q <= '0;
			pos_q <= '0;
		end else if (req.step) begin
			if (emit) begin
				acc_q <= '0;
				pos_q <= '0;
			end else begin
				acc_q <= bits_n;
				pos_q <= pos_q + 3'd1;
			end
		end
	end

	assign st.emit = emit;
	assign st.bits = bits_n;
	assign st.pos  = pos_q;

endmodule
